// File: design/bfd_pkg.sv
// Shared types and constants for the byte frame deframer.
package bfd_pkg;

    localparam int PAYLOAD_BYTES = 12;
    localparam int BYTE_W        = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [BYTE_W-1:0] START_FIRST_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] START_SECOND_RESET = 8'h55;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SECOND = 2'd1;

    typedef enum logic [2:0] {
        PH_SOF_A = 3'd0,
        PH_SOF_B = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } phase_t;

    typedef struct packed {
        logic shift_en;
        logic xor_init;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic first_hit;
        logic second_hit;
        logic len_ok;
        logic chk_ok;
        logic out_full;
    } dp_status_t;

endpackage

// File: design/bfd_ctrl.sv
// Frame parser state machine and payload byte counter.
module bfd_ctrl #(
    parameter int PAYLOAD_BYTES = bfd_pkg::PAYLOAD_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfd_pkg::dp_status_t status,
    output bfd_pkg::dp_cmd_t    cmd
);

    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

    bfd_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             accept;

    assign s_ready = (phase_reg != bfd_pkg::PH_CHECK) || !status.out_full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bfd_pkg::PH_SOF_A;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                bfd_pkg::PH_SOF_A: begin
                    if (status.first_hit) phase_next = bfd_pkg::PH_SOF_B;
                end
                bfd_pkg::PH_SOF_B: begin
                    if (status.second_hit)     phase_next = bfd_pkg::PH_LEN;
                    else if (status.first_hit) phase_next = bfd_pkg::PH_SOF_B;
                    else                       phase_next = bfd_pkg::PH_SOF_A;
                end
                bfd_pkg::PH_LEN: begin
                    phase_next = status.len_ok ? bfd_pkg::PH_DATA : bfd_pkg::PH_SOF_A;
                end
                bfd_pkg::PH_DATA: begin
                    if (count_reg == CNT_LAST) phase_next = bfd_pkg::PH_CHECK;
                end
                bfd_pkg::PH_CHECK: phase_next = bfd_pkg::PH_SOF_A;
                default:           phase_next = bfd_pkg::PH_SOF_A;
            endcase
        end
    end

    always_comb begin
        cmd        = '0;
        count_next = count_reg;
        if (accept) begin
            unique case (phase_reg)
                bfd_pkg::PH_LEN: begin
                    cmd.xor_init = status.len_ok;
                    count_next   = '0;
                end
                bfd_pkg::PH_DATA: begin
                    cmd.shift_en = 1'b1;
                    count_next   = count_reg + CNT_W'(1);
                end
                bfd_pkg::PH_CHECK: cmd.load_out = status.chk_ok;
                default: ;
            endcase
        end
    end

endmodule

// File: design/bfd_datapath.sv
// Start byte registers, payload shift store, running XOR and result register.
module bfd_datapath #(
    parameter int PAYLOAD_BYTES = bfd_pkg::PAYLOAD_BYTES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [bfd_pkg::BYTE_W-1:0]          s_rx_byte,
    input  bfd_pkg::dp_cmd_t                    cmd,
    output bfd_pkg::dp_status_t                 status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_version,
    output logic [7:0]                          m_source,
    output logic signed [15:0]                  m_command,
    output logic [15:0]                         m_sequence_res,
    output logic [15:0]                         m_confidence_q15,
    output logic [31:0]                         m_timestamp_ms
);

    localparam int BW = bfd_pkg::BYTE_W;

    logic [BW-1:0] start_first_reg, start_second_reg;
    logic [BW-1:0] xor_reg, xor_next;
    logic [BW-1:0] store_reg [PAYLOAD_BYTES];
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    version_reg, source_reg;
    logic [15:0]   command_reg, sequence_reg, confidence_reg;
    logic [31:0]   timestamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_first_reg  <= bfd_pkg::START_FIRST_RESET;
            start_second_reg <= bfd_pkg::START_SECOND_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bfd_pkg::CFG_START_FIRST:  start_first_reg  <= cfg_data[BW-1:0];
                bfd_pkg::CFG_START_SECOND: start_second_reg <= cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // Oldest payload byte ends up at entry 0.
    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[PAYLOAD_BYTES-1] <= s_rx_byte;
        end
    end

    always_comb begin
        xor_next = xor_reg;
        if (cmd.xor_init)      xor_next = BW'(PAYLOAD_BYTES);
        else if (cmd.shift_en) xor_next = xor_reg ^ s_rx_byte;
    end

    always_ff @(posedge aclk) begin
        xor_reg <= xor_next;
    end

    assign status.first_hit  = (s_rx_byte == start_first_reg);
    assign status.second_hit = (s_rx_byte == start_second_reg);
    assign status.len_ok     = (s_rx_byte == BW'(PAYLOAD_BYTES));
    assign status.chk_ok     = (s_rx_byte == xor_reg);
    assign status.out_full   = m_valid_reg && !m_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.load_out) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else          m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            version_reg    <= store_reg[0];
            source_reg     <= store_reg[1];
            command_reg    <= {store_reg[3], store_reg[2]};
            sequence_reg   <= {store_reg[5], store_reg[4]};
            confidence_reg <= {store_reg[7], store_reg[6]};
            timestamp_reg  <= {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_version        = version_reg;
    assign m_source         = source_reg;
    assign m_command        = signed'(command_reg);
    assign m_sequence_res   = sequence_reg;
    assign m_confidence_q15 = confidence_reg;
    assign m_timestamp_ms   = timestamp_reg;

endmodule

// File: design/byte_frame_deframer_xor.sv
// Top level of the byte frame deframer with XOR check.
//
// Usage:
//   s_* channel: one received byte per item (s_rx_byte), valid/ready.
//   m_* channel: one decoded frame per item, valid/ready, fields taken
//   little-endian from the 12 payload bytes.
//   cfg_*: write-only port for the two start-of-frame byte values
//   (index 0 first start byte, index 1 second start byte).
// Frame: start byte 1, start byte 2, length (must be 12), 12 payload
// bytes, then a check byte equal to the XOR of length and payload.
// Bad length or bad check drops the frame silently and resumes hunting.
// Throughput: one byte per cycle while s_ready is high; the running XOR is
// updated as each payload byte is taken. The frame appears on m_valid in the
// cycle after the check byte is accepted.
// Stall: a held result only blocks the next check byte; all other bytes
// keep flowing into the parser while the result waits.
// Reset: parser returns to hunting, start bytes return to 0xAA and 0x55,
// and no result is pending.
module byte_frame_deframer_xor #(
    parameter int PAYLOAD_BYTES = bfd_pkg::PAYLOAD_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_version,
    output logic [7:0]                      m_source,
    output logic signed [15:0]              m_command,
    output logic [15:0]                     m_sequence_res,
    output logic [15:0]                     m_confidence_q15,
    output logic [31:0]                     m_timestamp_ms
);

    bfd_pkg::dp_cmd_t    cmd;
    bfd_pkg::dp_status_t status;

    bfd_ctrl #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bfd_datapath #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_version        (m_version),
        .m_source         (m_source),
        .m_command        (m_command),
        .m_sequence_res   (m_sequence_res),
        .m_confidence_q15 (m_confidence_q15),
        .m_timestamp_ms   (m_timestamp_ms)
    );

endmodule

// File: design/bfd_checker.sv
// Port-level checks for the byte frame deframer, bound to the top level.
module bfd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [7:0]                      s_rx_byte,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [7:0]                      m_version,
    input logic [7:0]                      m_source,
    input logic signed [15:0]              m_command,
    input logic [15:0]                     m_sequence_res,
    input logic [15:0]                     m_confidence_q15,
    input logic [31:0]                     m_timestamp_ms
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_version) && $stable(m_source)
            && $stable(m_command) && $stable(m_sequence_res)
            && $stable(m_confidence_q15) && $stable(m_timestamp_ms))
        else $error("result item changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result item without an accepted byte");

    a_new_result_needs_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready ##1 m_valid |-> $past(s_valid && s_ready))
        else $error("repeated result item");

endmodule

bind byte_frame_deframer_xor bfd_checker u_bfd_checker (.*);
